### rtl/core/bdq_pkg.sv
// ----------------------------------------------------------------------------
// bdq_pkg
// Shared types and constants for the byte deque core: command and status
// codes, the controller state type and the controller-to-datapath commands.
// ----------------------------------------------------------------------------
package bdq_pkg;

  // default queue depth in bytes
  localparam int unsigned DEPTH_DEFAULT = 64;

  // field widths fixed by the interface
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned FILL_W   = 7;

  // command codes
  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_POP  = 1'b1;

  // status codes
  localparam logic [STATUS_W-1:0] STAT_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_RESP
  } ctrl_state_t;

  typedef struct packed {
    logic capture;  // latch the incoming request
    logic exec;     // update pointers and access the ring
  } dp_cmd_t;

endpackage

### rtl/core/bdq_ctrl.sv
// ----------------------------------------------------------------------------
// bdq_ctrl
// Sequencing for the byte deque: take a request, run it through the
// datapath, then hold the result until the receiver takes it.
// ----------------------------------------------------------------------------
module bdq_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  output logic            out_valid,
  input  logic            out_stall,
  output bdq_pkg::dp_cmd_t dp_cmd
);

  bdq_pkg::ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bdq_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bdq_pkg::S_IDLE: begin
        if (in_valid) state_nxt = bdq_pkg::S_EXEC;
      end
      bdq_pkg::S_EXEC: begin
        state_nxt = bdq_pkg::S_RESP;
      end
      bdq_pkg::S_RESP: begin
        if (!out_stall) state_nxt = bdq_pkg::S_IDLE;
      end
      default: state_nxt = bdq_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_stall       = 1'b1;
    out_valid      = 1'b0;
    dp_cmd.capture = 1'b0;
    dp_cmd.exec    = 1'b0;
    unique case (state_r)
      bdq_pkg::S_IDLE: begin
        in_stall       = 1'b0;
        dp_cmd.capture = in_valid;
      end
      bdq_pkg::S_EXEC: begin
        dp_cmd.exec = 1'b1;
      end
      bdq_pkg::S_RESP: begin
        out_valid = 1'b1;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

endmodule

### rtl/core/bdq_dp.sv
// ----------------------------------------------------------------------------
// bdq_dp
// Datapath of the byte deque: ring storage, head pointer, occupancy count
// and the registered result fields.
// ----------------------------------------------------------------------------
module bdq_dp #(
  parameter int unsigned DEPTH = bdq_pkg::DEPTH_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  bdq_pkg::dp_cmd_t               dp_cmd,
  input  logic                           in_command,
  input  logic                           in_at_front,
  input  logic [bdq_pkg::BYTE_W-1:0]     in_push_byte,
  output logic [bdq_pkg::BYTE_W-1:0]     out_popped_byte,
  output logic [bdq_pkg::STATUS_W-1:0]   out_status,
  output logic [bdq_pkg::FILL_W-1:0]     out_fill_count,
  output logic                           out_is_empty,
  output logic                           out_is_full
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned SW = CW + 1;
  localparam logic [CW-1:0] DEPTH_C    = CW'(DEPTH);
  localparam logic [AW-1:0] LAST_IDX   = AW'(DEPTH - 1);
  localparam logic [SW-1:0] DEPTH_S    = SW'(DEPTH);

  logic [bdq_pkg::BYTE_W-1:0] mem [DEPTH];

  logic                        head_cmd_r;
  logic                        front_r;
  logic [bdq_pkg::BYTE_W-1:0]  byte_r;
  logic [AW-1:0]               head_r, head_nxt;
  logic [CW-1:0]               occ_r, occ_nxt;
  logic [bdq_pkg::STATUS_W-1:0] status_r, status_nxt;
  logic                        pop_ok_r, pop_ok_nxt;
  logic [bdq_pkg::BYTE_W-1:0]  rd_data_r;

  logic [CW-1:0] ofs;
  logic [SW-1:0] pos_sum;
  logic [AW-1:0] pos;
  logic [AW-1:0] head_dec;
  logic [AW-1:0] addr;
  logic          wr_en;
  logic          rd_en;
  logic          is_full;
  logic          is_empty;

  assign is_full  = (occ_r == DEPTH_C);
  assign is_empty = (occ_r == '0);

  // one shared ring-position adder for back-end access and head advance
  always_comb begin
    if (head_cmd_r == bdq_pkg::CMD_POP) begin
      ofs = front_r ? CW'(1) : (occ_r - CW'(1));
    end else begin
      ofs = occ_r;
    end
    pos_sum = SW'(head_r) + SW'(ofs);
    if (pos_sum >= DEPTH_S) pos_sum = pos_sum - DEPTH_S;
    pos = pos_sum[AW-1:0];
  end

  assign head_dec = (head_r == '0) ? LAST_IDX : (head_r - AW'(1));

  always_comb begin
    head_nxt   = head_r;
    occ_nxt    = occ_r;
    status_nxt = bdq_pkg::STAT_DONE;
    pop_ok_nxt = 1'b0;
    addr       = pos;
    wr_en      = 1'b0;
    rd_en      = 1'b0;
    if (head_cmd_r == bdq_pkg::CMD_PUSH) begin
      if (is_full) begin
        status_nxt = bdq_pkg::STAT_FULL;
      end else begin
        wr_en   = dp_cmd.exec;
        occ_nxt = occ_r + CW'(1);
        if (front_r) begin
          addr     = head_dec;
          head_nxt = head_dec;
        end
      end
    end else begin
      if (is_empty) begin
        status_nxt = bdq_pkg::STAT_EMPTY;
      end else begin
        rd_en      = dp_cmd.exec;
        pop_ok_nxt = 1'b1;
        occ_nxt    = occ_r - CW'(1);
        if (front_r) begin
          addr     = head_r;
          head_nxt = pos;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      occ_r  <= '0;
    end else if (dp_cmd.exec) begin
      head_r <= head_nxt;
      occ_r  <= occ_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.capture) begin
      head_cmd_r <= in_command;
      front_r    <= in_at_front;
      byte_r     <= in_push_byte;
    end
    if (dp_cmd.exec) begin
      status_r <= status_nxt;
      pop_ok_r <= pop_ok_nxt;
    end
  end

  // ring storage, one port, registered read
  always_ff @(posedge clk) begin
    if (wr_en) mem[addr] <= byte_r;
    if (rd_en) rd_data_r <= mem[addr];
  end

  assign out_popped_byte = pop_ok_r ? rd_data_r : '0;
  assign out_status      = status_r;
  assign out_fill_count  = bdq_pkg::FILL_W'(occ_r);
  assign out_is_empty    = is_empty;
  assign out_is_full     = is_full;

endmodule

### rtl/core/byte_deque_core.sv
// ----------------------------------------------------------------------------
// byte_deque_core
// Bounded double-ended byte queue with push and pop at either end.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall): one request per transfer. in_command
// selects push or pop, in_at_front picks the end, in_push_byte is stored on
// a push. Result channel (out_valid / out_stall): one result per request
// with the popped byte, a status code, the fill count and empty/full flags.
// A push into a full queue is dropped with full status; a pop from an empty
// queue returns zero with empty status. Neither changes the queue.
// Sequencing: the controller captures a request in idle, drives the ring
// access in exec and then holds the result until the receiver takes it.
// No new request is taken before the previous result has left, so requests
// never overlap; the single-port ring memory read is registered in the exec
// step, between capture and result hold.
// A stalled result holds steady and no new request is taken until it goes.
// Reset (rst_n low, synchronous) empties the queue and returns the
// controller to idle; ring contents are not cleared and need no sweep.
// ----------------------------------------------------------------------------
module byte_deque_core #(
  parameter int unsigned DEPTH = bdq_pkg::DEPTH_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_command,
  input  logic                         in_at_front,
  input  logic [bdq_pkg::BYTE_W-1:0]   in_push_byte,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [bdq_pkg::BYTE_W-1:0]   out_popped_byte,
  output logic [bdq_pkg::STATUS_W-1:0] out_status,
  output logic [bdq_pkg::FILL_W-1:0]   out_fill_count,
  output logic                         out_is_empty,
  output logic                         out_is_full
);

  bdq_pkg::dp_cmd_t dp_cmd;

  bdq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .dp_cmd    (dp_cmd)
  );

  bdq_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .dp_cmd          (dp_cmd),
    .in_command      (in_command),
    .in_at_front     (in_at_front),
    .in_push_byte    (in_push_byte),
    .out_popped_byte (out_popped_byte),
    .out_status      (out_status),
    .out_fill_count  (out_fill_count),
    .out_is_empty    (out_is_empty),
    .out_is_full     (out_is_full)
  );

  // no new request while a result is pending
  a_no_accept_while_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |-> !out_valid)
    else $error("request taken while a result is pending");

  // an empty pop reports an empty queue and a zero byte
  a_empty_pop: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == bdq_pkg::STAT_EMPTY) |->
      (out_is_empty && out_popped_byte == '0))
    else $error("empty pop result inconsistent");

  // a dropped push only happens on a full queue
  a_full_push: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == bdq_pkg::STAT_FULL) |-> out_is_full)
    else $error("push dropped on a queue that is not full");

  // the queue is never both empty and full
  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_is_empty && out_is_full))
    else $error("empty and full both set");

endmodule
